FILE: rtl/dirty_slot_table_paced_flush_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dirty slot table
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIRTY_SLOT_TABLE_PACED_FLUSH_CORE_DEFINES_SVH
`define DIRTY_SLOT_TABLE_PACED_FLUSH_CORE_DEFINES_SVH

// Same-cycle implication
`define DSTPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DSTPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dstpf_pkg.sv
// ----------------------------------------------------------------------------
// dstpf_pkg
// Shared types and constants of the dirty slot table with paced flush.
// ----------------------------------------------------------------------------
package dstpf_pkg;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int SLOT_W      = 8;
    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int SPACING_W   = 20;
    localparam int SEND_SLOT_W = 5;

    // Spacing after reset: 15 ms
    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(15 * 1000);

    // Item commands; code 3 is reserved and does nothing
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_POLL  = 2'd2
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;     // apply the accepted word and load the result register
    } ctrl_t;

endpackage

FILE: rtl/dirty_slot_table_paced_flush_core.sv
// ----------------------------------------------------------------------------
// dirty_slot_table_paced_flush_core
// Slot ID table with dirty tracking and rate-limited update sends.
// ----------------------------------------------------------------------------
// Each input word is one command: write one slot, clear all slots, or poll.
// Writes and clears mark a slot dirty only when its stored ID changes; writes
// to a slot at or beyond NUM_SLOTS are dropped. A poll sends the lowest dirty
// slot when at least spacing_reg microseconds (wrapping) have passed since
// the last send; the dirty bit is cleared only if link_ready was high. Every
// word gives exactly one result word. A word is executed in the cycle it is
// accepted, so the block takes one word per clock; the single result register
// is the only limit, and in_ready drops only while a result waits and
// out_ready is low. After reset all slots are dirty, the last send time is 0
// and the spacing is 15000 us. cfg_wr_en writes the spacing at once.
// ----------------------------------------------------------------------------
module dirty_slot_table_paced_flush_core
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [dstpf_pkg::SPACING_W-1:0]      cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dstpf_pkg::CMD_W-1:0]          cmd,
    input  logic [dstpf_pkg::SLOT_W-1:0]         slot,
    input  logic [dstpf_pkg::ID_W-1:0]           obj_id,
    input  logic [dstpf_pkg::TIME_W-1:0]         now_us,
    input  logic                                 link_ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 send_valid,
    output logic [dstpf_pkg::SEND_SLOT_W-1:0]    send_slot,
    output logic [dstpf_pkg::ID_W-1:0]           send_id,
    output logic                                 any_pending
);

    dstpf_pkg::ctrl_t ctrl;

    // Handshake controller
    dstpf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // Table and result datapath
    dstpf_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .slot        (slot),
        .obj_id      (obj_id),
        .now_us      (now_us),
        .link_ready  (link_ready),
        .send_valid  (send_valid),
        .send_slot   (send_slot),
        .send_id     (send_id),
        .any_pending (any_pending)
    );

endmodule

FILE: rtl/dstpf_ctrl.sv
// ----------------------------------------------------------------------------
// dstpf_ctrl
// Handshake controller: tracks the result register and issues execute.
// ----------------------------------------------------------------------------
`include "dirty_slot_table_paced_flush_core_defines.svh"

module dstpf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dstpf_pkg::ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a word when the result register is empty or being drained
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign ctrl.exec = in_valid && in_ready;

    // Next state
    always_comb
    begin
        unique case (state_reg)
            ST_EMPTY:
            begin
                state_next = ctrl.exec ? ST_FULL : ST_EMPTY;
            end
            ST_FULL:
            begin
                if (ctrl.exec)
                    state_next = ST_FULL;
                else if (out_ready)
                    state_next = ST_EMPTY;
                else
                    state_next = ST_FULL;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

    // A pending result is never overwritten before it is taken
    `DSTPF_ASSERT_IMPL(a_no_overwrite, ctrl.exec && state_reg == ST_FULL, out_ready, "result overwritten")

endmodule

FILE: rtl/dstpf_datapath.sv
// ----------------------------------------------------------------------------
// dstpf_datapath
// Slot table, dirty mask, send timer, spacing register and result register.
// ----------------------------------------------------------------------------
`include "dirty_slot_table_paced_flush_core_defines.svh"

module dstpf_datapath
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dstpf_pkg::ctrl_t                     ctrl,
    input  logic                                 cfg_wr_en,
    input  logic [dstpf_pkg::SPACING_W-1:0]      cfg_wr_data,
    input  logic [dstpf_pkg::CMD_W-1:0]          cmd,
    input  logic [dstpf_pkg::SLOT_W-1:0]         slot,
    input  logic [dstpf_pkg::ID_W-1:0]           obj_id,
    input  logic [dstpf_pkg::TIME_W-1:0]         now_us,
    input  logic                                 link_ready,
    output logic                                 send_valid,
    output logic [dstpf_pkg::SEND_SLOT_W-1:0]    send_slot,
    output logic [dstpf_pkg::ID_W-1:0]           send_id,
    output logic                                 any_pending
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef logic [dstpf_pkg::SLOT_W-1:0]      slot_num_t;
    typedef logic [IDX_W-1:0]                  idx_t;
    typedef logic [dstpf_pkg::SEND_SLOT_W-1:0] send_slot_t;
    typedef logic [dstpf_pkg::ID_W-1:0]        id_t;
    typedef logic [dstpf_pkg::TIME_W-1:0]      time_val_t;

    // Table state
    id_t                              ids_reg   [NUM_SLOTS];
    id_t                              ids_next  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]             dirty_reg;
    logic [NUM_SLOTS-1:0]             dirty_next;
    time_val_t                        last_send_reg;
    time_val_t                        last_send_next;
    logic [dstpf_pkg::SPACING_W-1:0]  spacing_reg;

    // Result register
    logic                             send_valid_reg;
    logic                             send_valid_next;
    send_slot_t                       send_slot_reg;
    send_slot_t                       send_slot_next;
    id_t                              send_id_reg;
    id_t                              send_id_next;
    logic                             any_pending_reg;

    // Poll helpers
    logic                             found;
    idx_t                             send_idx;
    time_val_t                        elapsed;
    logic                             time_ok;
    logic                             poll_send;

    // Lowest dirty slot
    always_comb
    begin
        found    = 1'b0;
        send_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (dirty_reg[i] && !found)
            begin
                found    = 1'b1;
                send_idx = idx_t'(i);
            end
        end
    end

    // Wrapping time since the last send against the spacing
    assign elapsed   = now_us - last_send_reg;
    assign time_ok   = elapsed >= time_val_t'(spacing_reg);
    assign poll_send = (cmd == dstpf_pkg::CMD_POLL) && found && time_ok;

    // Item execution
    always_comb
    begin
        ids_next        = ids_reg;
        dirty_next      = dirty_reg;
        last_send_next  = last_send_reg;
        send_valid_next = 1'b0;
        send_slot_next  = '0;
        send_id_next    = '0;
        case (cmd)
            dstpf_pkg::CMD_WRITE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot == slot_num_t'(i) && ids_reg[i] != obj_id)
                    begin
                        ids_next[i]   = obj_id;
                        dirty_next[i] = 1'b1;
                    end
                end
            end
            dstpf_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (ids_reg[i] != '0)
                    begin
                        ids_next[i]   = '0;
                        dirty_next[i] = 1'b1;
                    end
                end
            end
            dstpf_pkg::CMD_POLL:
            begin
                if (poll_send)
                begin
                    send_valid_next = 1'b1;
                    send_slot_next  = send_slot_t'(send_idx);
                    send_id_next    = ids_reg[send_idx];
                    last_send_next  = now_us;
                    if (link_ready)
                        dirty_next[send_idx] = 1'b0;
                end
            end
            default:
            begin
                // reserved command: no change
            end
        endcase
    end

    // Table state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                ids_reg[i] <= '0;
            dirty_reg     <= '1;
            last_send_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            ids_reg       <= ids_next;
            dirty_reg     <= dirty_next;
            last_send_reg <= last_send_next;
        end
    end

    // Spacing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= dstpf_pkg::SPACING_RESET;
        else if (cfg_wr_en)
            spacing_reg <= cfg_wr_data;
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            send_valid_reg  <= send_valid_next;
            send_slot_reg   <= send_slot_next;
            send_id_reg     <= send_id_next;
            any_pending_reg <= |dirty_next;
        end
    end

    assign send_valid  = send_valid_reg;
    assign send_slot   = send_slot_reg;
    assign send_id     = send_id_reg;
    assign any_pending = any_pending_reg;

    // An accepted send clears exactly the sent slot's dirty bit
    `DSTPF_ASSERT_NEXT(a_sent_cleared, ctrl.exec && poll_send && link_ready, !dirty_reg[$past(send_idx)], "sent slot still dirty")
    // Every send stamps the poll time
    `DSTPF_ASSERT_NEXT(a_time_stamped, ctrl.exec && poll_send, last_send_reg == $past(now_us), "send time not recorded")
    // Pending flag agrees with the mask it was taken from
    `DSTPF_ASSERT_NEXT(a_pending_match, ctrl.exec, any_pending_reg == (|dirty_reg), "pending flag mismatch")

endmodule
